// ----- rtl/bitmap_frame_allocator_assert.svh -----
// assertion macros shared by the frame allocator checks
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BFA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define BFA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ----- rtl/bfa_pkg.sv -----
// types, constants and codes of the bitmap frame allocator
package bfa_pkg;

	localparam int FRAME_W     = 12;
	localparam int COUNT_W     = 13;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;
	localparam int WORD_W      = 32;
	localparam int BIT_LG      = 5;
	localparam int MAX_WORDS   = 128;
	localparam int WORD_AW     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

	// availability scan: one group of words per cycle
	localparam int SCAN_W      = 16;
	localparam int SCAN_LG     = 4;
	localparam int SCAN_STEPS  = (MAX_WORDS + SCAN_W - 1) / SCAN_W;
	localparam int GRP_W       = (SCAN_STEPS > 1) ? $clog2(SCAN_STEPS) : 1;
	localparam int PAD_WORDS   = (1 << GRP_W) * SCAN_W;
	localparam int PAD_AW      = GRP_W + SCAN_LG;
	localparam int LIM_W       = COUNT_W - BIT_LG;
	localparam int CMP_W       = (PAD_AW > LIM_W) ? PAD_AW : LIM_W;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_NOTHING  = 2'd1;
	localparam logic [1:0] ST_NO_FRAME = 2'd2;

	typedef enum logic [1:0] {
		RES_NOTHING,
		RES_NO_FRAME,
		RES_FREED,
		RES_ALLOCATED
	} res_kind_t;

	typedef struct packed {
		logic               kind;
		logic [FRAME_W-1:0] current_frame;
		logic               kernel_page;
		logic               write_page;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_index;
		logic               present;
		logic               writeable;
		logic               user_mode;
		logic [1:0]         status;
	} res_t;

	typedef struct packed {
		logic      capture;
		logic      scan_start;
		logic      scan_step;
		logic      rd;
		logic      wr;
		logic      res_set;
		res_kind_t res_kind;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic is_alloc;
		logic cur_zero;
		logic in_map;
		logic scan_hit;
		logic scan_last;
	} stat_t;

endpackage

// ----- rtl/bfa_ctrl.sv -----
// request sequencer of the frame allocator
module bfa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  bfa_pkg::stat_t stat,
	output bfa_pkg::cmd_t  cmd
);
	import bfa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_READ,
		S_MODIFY,
		S_RESULT
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.cur_zero) begin
					if (stat.is_alloc) begin
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end else begin
						cmd.res_set  = 1'b1;
						cmd.res_kind = RES_NOTHING;
						state_d      = S_RESULT;
					end
				end else if (stat.is_alloc) begin
					cmd.res_set  = 1'b1;
					cmd.res_kind = RES_NOTHING;
					state_d      = S_RESULT;
				end else if (stat.in_map) begin
					cmd.rd  = 1'b1;
					state_d = S_MODIFY;
				end else begin
					cmd.res_set  = 1'b1;
					cmd.res_kind = RES_FREED;
					state_d      = S_RESULT;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_hit) begin
					state_d = S_READ;
				end else if (stat.scan_last) begin
					cmd.res_set  = 1'b1;
					cmd.res_kind = RES_NO_FRAME;
					state_d      = S_RESULT;
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_MODIFY;
			end
			S_MODIFY: begin
				cmd.wr       = 1'b1;
				cmd.res_set  = 1'b1;
				cmd.res_kind = stat.is_alloc ? RES_ALLOCATED : RES_FREED;
				state_d      = S_RESULT;
			end
			S_RESULT: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/bfa_dp.sv -----
// bitmap store, availability scan and result path of the frame allocator
module bfa_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bfa_pkg::COUNT_W-1:0]   cfg_data,
	input  bfa_pkg::req_t                 in_req,
	input  bfa_pkg::cmd_t                 cmd,
	output bfa_pkg::stat_t                stat,
	output bfa_pkg::res_t                 out_res
);
	import bfa_pkg::*;

	logic [WORD_W-1:0]    mem_q [MAX_WORDS];
	logic [MAX_WORDS-1:0] valid_q;
	logic [MAX_WORDS-1:0] full_q;
	logic [COUNT_W-1:0]   frame_count_q;
	req_t                 req_q;
	logic [WORD_AW-1:0]   addr_q;
	logic [GRP_W-1:0]     grp_q;
	logic [WORD_W-1:0]    rd_word_s1;
	logic                 rd_vld_s1;
	res_t                 res_q;
	res_t                 out_q;

	logic [PAD_WORDS-1:0] full_pad;
	logic [SCAN_W-1:0]    grp_avail;
	logic [SCAN_LG-1:0]   hit_idx;
	logic [LIM_W-1:0]     lim;
	logic [WORD_W-1:0]    word;
	logic [WORD_W-1:0]    new_word;
	logic [BIT_LG-1:0]    zero_bit;
	res_t                 res_d;

	// words past the map read as full
	assign full_pad = ~PAD_WORDS'(~full_q);
	assign lim      = frame_count_q[COUNT_W-1:BIT_LG];

	always_comb begin
		for (int i = 0; i < SCAN_W; i++) begin
			grp_avail[i] = !full_pad[{grp_q, SCAN_LG'(0)} + PAD_AW'(i)]
				&& (CMP_W'({grp_q, SCAN_LG'(i)}) < CMP_W'(lim));
		end
	end

	always_comb begin
		hit_idx = '0;
		for (int i = SCAN_W - 1; i >= 0; i--) begin
			if (grp_avail[i]) begin
				hit_idx = SCAN_LG'(i);
			end
		end
	end

	assign word = rd_vld_s1 ? rd_word_s1 : '0;

	always_comb begin
		zero_bit = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (!word[b]) begin
				zero_bit = BIT_LG'(b);
			end
		end
	end

	always_comb begin
		if (req_q.kind == KIND_ALLOC) begin
			new_word = word | (WORD_W'(1) << zero_bit);
		end else begin
			new_word = word & ~(WORD_W'(1) << req_q.current_frame[BIT_LG-1:0]);
		end
	end

	always_comb begin
		res_d        = '0;
		res_d.status = ST_DONE;
		case (cmd.res_kind)
			RES_NOTHING: begin
				res_d.frame_index = req_q.current_frame;
				res_d.status      = ST_NOTHING;
			end
			RES_NO_FRAME: begin
				res_d.status = ST_NO_FRAME;
			end
			RES_FREED: begin
				res_d.status = ST_DONE;
			end
			RES_ALLOCATED: begin
				res_d.frame_index = FRAME_W'({addr_q, zero_bit});
				res_d.present     = 1'b1;
				res_d.writeable   = req_q.write_page;
				res_d.user_mode   = !req_q.kernel_page;
			end
			default: begin
				res_d.status = ST_DONE;
			end
		endcase
	end

	assign stat.is_alloc  = (req_q.kind == KIND_ALLOC);
	assign stat.cur_zero  = (req_q.current_frame == '0);
	assign stat.in_map    = (int'(req_q.current_frame[FRAME_W-1:BIT_LG]) < MAX_WORDS);
	assign stat.scan_hit  = |grp_avail;
	assign stat.scan_last = (grp_q == GRP_W'(SCAN_STEPS - 1));
	assign out_res        = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			full_q        <= '0;
			frame_count_q <= COUNT_RESET;
		end else begin
			if (cfg_we) begin
				frame_count_q <= cfg_data;
			end
			if (cmd.wr) begin
				valid_q[addr_q] <= 1'b1;
				full_q[addr_q]  <= (req_q.kind == KIND_ALLOC) ? (&new_word) : 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= in_req;
			addr_q <= WORD_AW'(in_req.current_frame[FRAME_W-1:BIT_LG]);
		end else if (cmd.scan_step && stat.scan_hit) begin
			addr_q <= WORD_AW'({grp_q, hit_idx});
		end
		if (cmd.scan_start) begin
			grp_q <= '0;
		end else if (cmd.scan_step) begin
			grp_q <= grp_q + GRP_W'(1);
		end
		if (cmd.rd) begin
			rd_word_s1 <= mem_q[addr_q];
			rd_vld_s1  <= valid_q[addr_q];
		end
		if (cmd.wr) begin
			mem_q[addr_q] <= new_word;
		end
		if (cmd.res_set) begin
			res_q <= res_d;
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

endmodule

// ----- rtl/bitmap_frame_allocator.sv -----
// top level of the first-fit bitmap frame allocator
//
//   channel  handshake             payload
//   in       in_valid / in_stall   in_req  (kind, current_frame, kernel_page, write_page)
//   out      out_valid / out_stall out_res (frame_index, present, writeable, user_mode, status)
//   cfg      cfg_we                cfg_data (frame_count)
//
// one request at a time; a request with nothing to do and a free skip the scan,
// an allocate scans g 16-word groups (1 to 8), all 8 for a full map
// the scan checks one group of per-word full flags each cycle, then one bitmap read
// and one write back on the single memory port
// reset clears the per-word valid and full flags at once: no clearing pass
// a waiting result sits in the output register; a new request is taken meanwhile
module bitmap_frame_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  bfa_pkg::req_t               in_req,
	output logic                        out_valid,
	input  logic                        out_stall,
	output bfa_pkg::res_t               out_res,
	input  logic                        cfg_we,
	input  logic [bfa_pkg::COUNT_W-1:0] cfg_data
);
	import bfa_pkg::*;

	// controller to datapath commands and datapath status back
	cmd_t  cmd;
	stat_t stat;

	// sequencer: dispatch, group scan, read, modify, result hand-off
	bfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// bitmap memory, full flags, frame count register and result registers
	bfa_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_req   (in_req),
		.cmd      (cmd),
		.stat     (stat),
		.out_res  (out_res)
	);

endmodule

// ----- rtl/bfa_checker.sv -----
// port checks of the frame allocator and their bind
`include "bitmap_frame_allocator_assert.svh"

module bfa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input bfa_pkg::req_t in_req,
	input logic          out_valid,
	input logic          out_stall,
	input bfa_pkg::res_t out_res
);
	import bfa_pkg::*;

	logic in_acc;

	assign in_acc = in_valid && !in_stall && (in_req.kind == KIND_ALLOC || in_req.kind == KIND_FREE);

	// one request in flight: busy right after an accept
	`BFA_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall)
	// a stalled result stays put
	`BFA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_res))
	// no undefined status code
	`BFA_ASSERT_NOW(a_status_code, out_valid,
		out_res.status == ST_DONE || out_res.status == ST_NOTHING
		|| out_res.status == ST_NO_FRAME)
	// flags only come with a completed allocation
	`BFA_ASSERT_NOW(a_flags_done, out_valid && out_res.status != ST_DONE,
		!out_res.present && !out_res.writeable && !out_res.user_mode)
	// a full map hands out no frame
	`BFA_ASSERT_NOW(a_full_zero, out_valid && out_res.status == ST_NO_FRAME,
		out_res.frame_index == '0)

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (.*);

// ----- dv/tb_bitmap_frame_allocator.sv -----
// testbench of the bitmap frame allocator: directed table, then random requests checked against a predictor
module tb_bitmap_frame_allocator;
	import bfa_pkg::*;

	// an allocate scans at most 8 word groups; the settle time leaves some margin over that
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 230;
	localparam int MAX_REPORTS   = 40;
	localparam int DIRECTED_LEN  = 21;

	// a row of the directed table is either a request or a frame_count write
	typedef enum logic {
		ROW_REQ,
		ROW_CFG
	} row_op_t;

	typedef struct packed {
		row_op_t            op;
		req_t               req;
		logic [COUNT_W-1:0] count;
		logic               typed;   // expected result given in the row itself
		res_t               res;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	req_t               in_req;
	logic               out_valid;
	logic               out_stall;
	res_t               out_res;
	logic               cfg_we;
	logic [COUNT_W-1:0] cfg_data;

	// predictor state: used/free bitmap and the managed frame count
	logic [WORD_W-1:0]  used_frames [MAX_WORDS];
	logic [COUNT_W-1:0] managed_frames;

	res_t        pending_results [$];   // expected results, oldest first
	int unsigned held_frames [$];       // frames handed out and not yet freed by the stimulus

	int    errors = 0;
	int    results_seen = 0;
	int    n_granted = 0;
	int    n_released = 0;
	int    n_nothing = 0;
	int    n_full = 0;
	int    sender_idle_pct = 0;
	int    stall_pct = 0;
	longint cycles = 0;

	// directed part: extremes, every kind of request, every special case
	stim_row_t directed_rows [DIRECTED_LEN] = '{
		// after reset: frame zero is an ordinary frame and goes first
		'{ROW_REQ, '{KIND_ALLOC, 12'd0, 1'b0, 1'b1}, 13'd0, 1'b1,
			'{12'd0, 1'b1, 1'b1, 1'b1, ST_DONE}},
		// kernel page, read only
		'{ROW_REQ, '{KIND_ALLOC, 12'd0, 1'b1, 1'b0}, 13'd0, 1'b1,
			'{12'd1, 1'b1, 1'b0, 1'b0, ST_DONE}},
		// entry already holds a frame, top frame number
		'{ROW_REQ, '{KIND_ALLOC, 12'd4095, 1'b1, 1'b1}, 13'd0, 1'b1,
			'{12'd4095, 1'b0, 1'b0, 1'b0, ST_NOTHING}},
		// free of an entry that holds no frame
		'{ROW_REQ, '{KIND_FREE, 12'd0, 1'b0, 1'b0}, 13'd0, 1'b1,
			'{12'd0, 1'b0, 1'b0, 1'b0, ST_NOTHING}},
		// free of a frame that was never used stays clear
		'{ROW_REQ, '{KIND_FREE, 12'd4095, 1'b1, 1'b1}, 13'd0, 1'b1,
			'{12'd0, 1'b0, 1'b0, 1'b0, ST_DONE}},
		'{ROW_REQ, '{KIND_FREE, 12'd1, 1'b0, 1'b1}, 13'd0, 1'b1,
			'{12'd0, 1'b0, 1'b0, 1'b0, ST_DONE}},
		// freed frame is handed out again
		'{ROW_REQ, '{KIND_ALLOC, 12'd0, 1'b0, 1'b0}, 13'd0, 1'b0, '0},
		// no words scanned: the map reads as full
		'{ROW_CFG, '0, 13'd0, 1'b0, '0},
		'{ROW_REQ, '{KIND_ALLOC, 12'd0, 1'b0, 1'b1}, 13'd0, 1'b1,
			'{12'd0, 1'b0, 1'b0, 1'b0, ST_NO_FRAME}},
		'{ROW_REQ, '{KIND_FREE, 12'd1, 1'b1, 1'b0}, 13'd0, 1'b1,
			'{12'd0, 1'b0, 1'b0, 1'b0, ST_DONE}},
		// a partial word is not scanned
		'{ROW_CFG, '0, 13'd31, 1'b0, '0},
		'{ROW_REQ, '{KIND_ALLOC, 12'd0, 1'b1, 1'b1}, 13'd0, 1'b1,
			'{12'd0, 1'b0, 1'b0, 1'b0, ST_NO_FRAME}},
		'{ROW_CFG, '0, 13'd32, 1'b0, '0},
		'{ROW_REQ, '{KIND_ALLOC, 12'd0, 1'b1, 1'b1}, 13'd0, 1'b0, '0},
		'{ROW_REQ, '{KIND_ALLOC, 12'd0, 1'b0, 1'b0}, 13'd0, 1'b0, '0},
		// largest count: the scan is capped at the map size
		'{ROW_CFG, '0, 13'd8191, 1'b0, '0},
		'{ROW_REQ, '{KIND_ALLOC, 12'd0, 1'b0, 1'b1}, 13'd0, 1'b0, '0},
		'{ROW_REQ, '{KIND_FREE, 12'd2048, 1'b0, 1'b0}, 13'd0, 1'b1,
			'{12'd0, 1'b0, 1'b0, 1'b0, ST_DONE}},
		'{ROW_REQ, '{KIND_ALLOC, 12'hAAA, 1'b0, 1'b0}, 13'd0, 1'b1,
			'{12'hAAA, 1'b0, 1'b0, 1'b0, ST_NOTHING}},
		'{ROW_REQ, '{KIND_FREE, 12'h555, 1'b1, 1'b1}, 13'd0, 1'b1,
			'{12'd0, 1'b0, 1'b0, 1'b0, ST_DONE}},
		'{ROW_CFG, '0, 13'd4096, 1'b0, '0}
	};

	bitmap_frame_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_results.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// page-entry update for one request; updates the predictor bitmap
	function automatic res_t predict_entry_update(req_t r);
		res_t res;
		int   words;
		int   found;
		int   w;
		int   b;
		res = '0;
		found = -1;
		if (r.kind == KIND_ALLOC) begin
			if (r.current_frame != '0) begin
				// entry already holds a frame: report it back, nothing else
				res.frame_index = r.current_frame;
				res.status = ST_NOTHING;
			end else begin
				// only whole words, never beyond the map
				words = int'(managed_frames) / WORD_W;
				if (words > MAX_WORDS)
					words = MAX_WORDS;
				for (w = 0; w < words && found < 0; w++)
					for (b = 0; b < WORD_W && found < 0; b++)
						if (!used_frames[w][b])
							found = w * WORD_W + b;
				if (found < 0) begin
					res.status = ST_NO_FRAME;
				end else begin
					used_frames[found / WORD_W][found % WORD_W] = 1'b1;
					res.frame_index = FRAME_W'(found);
					res.present = 1'b1;
					res.writeable = r.write_page;
					res.user_mode = ~r.kernel_page;
					res.status = ST_DONE;
				end
			end
		end else if (r.current_frame == '0) begin
			res.status = ST_NOTHING;
		end else begin
			// the frame number is the index itself, not an address
			if (int'(r.current_frame) / WORD_W < MAX_WORDS)
				used_frames[int'(r.current_frame) / WORD_W][int'(r.current_frame) % WORD_W] = 1'b0;
			res.status = ST_DONE;
		end
		return res;
	endfunction

	function automatic void compare_field(string name, int want, int got);
		if (want != got) begin
			if (errors < MAX_REPORTS)
				$display("%0t mismatch in %s: expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// result side: check accepted results, stall at random
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				if (errors < MAX_REPORTS)
					$display("%0t unexpected result: frame %0d status %0d", $time,
						out_res.frame_index, out_res.status);
				errors++;
			end else begin
				res_t want;
				want = pending_results.pop_front();
				compare_field("frame_index", want.frame_index, out_res.frame_index);
				compare_field("present", want.present, out_res.present);
				compare_field("writeable", want.writeable, out_res.writeable);
				compare_field("user_mode", want.user_mode, out_res.user_mode);
				compare_field("status", want.status, out_res.status);
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// present one request until taken; the expectation is formed at acceptance
	task automatic send_request(req_t r, logic typed, res_t typed_res);
		res_t predicted;
		in_valid <= 1'b1;
		in_req <= r;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		predicted = predict_entry_update(r);
		pending_results.push_back(typed ? typed_res : predicted);
		case (predicted.status)
			ST_DONE: begin
				if (r.kind == KIND_ALLOC) begin
					n_granted++;
					held_frames.push_back(predicted.frame_index);
				end else begin
					n_released++;
				end
			end
			ST_NOTHING: n_nothing++;
			default: n_full++;
		endcase
	endtask

	// random gap between requests; valid stays up when there is none
	task automatic sender_gap();
		int gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending until every expected result is back and the block has settled
	task automatic wait_until_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_frame_count(logic [COUNT_W-1:0] value);
		wait_until_drained();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		managed_frames = value;
		cfg_we <= 1'b0;
	endtask

	// mostly allocates and frees of held frames, so small maps fill and churn
	function automatic req_t random_request();
		req_t r;
		int   pick;
		int   idx;
		r.kernel_page = 1'($urandom_range(1));
		r.write_page = 1'($urandom_range(1));
		pick = $urandom_range(99);
		if (pick < 45) begin
			r.kind = KIND_ALLOC;
			r.current_frame = '0;
		end else if (pick < 55) begin
			// entry already mapped
			r.kind = KIND_ALLOC;
			r.current_frame = FRAME_W'($urandom_range(4095, 1));
		end else if (pick < 85 && held_frames.size() != 0) begin
			r.kind = KIND_FREE;
			idx = $urandom_range(held_frames.size() - 1);
			r.current_frame = FRAME_W'(held_frames[idx]);
			held_frames.delete(idx);
		end else if (pick < 95) begin
			// any frame, used or not
			r.kind = KIND_FREE;
			r.current_frame = FRAME_W'($urandom_range(4095));
		end else begin
			r.kind = KIND_FREE;
			r.current_frame = '0;
		end
		return r;
	endfunction

	initial begin
		logic [COUNT_W-1:0] count;
		int                 p;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_req <= '0;
		out_stall <= 1'b0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		foreach (used_frames[i])
			used_frames[i] = '0;
		managed_frames = COUNT_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling
		foreach (directed_rows[i]) begin
			if (directed_rows[i].op == ROW_CFG) begin
				write_frame_count(directed_rows[i].count);
			end else begin
				send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
			end
		end

		// random phases: each a frame_count setting and an idling mix
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: count = 13'd4096;
				1: count = 13'd32;
				2: count = 13'd64;
				3: count = 13'd8191;
				4: count = 13'd0;
				5: count = 13'd96;
				6: count = 13'd4095;
				default: count = COUNT_W'($urandom_range(8191));
			endcase
			write_frame_count(count);
			case (p % 4)
				0: begin
					sender_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 49;
					stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					stall_pct = 49;
				end
				default: begin
					sender_idle_pct = 34;
					stall_pct = 34;
				end
			endcase
			repeat (PHASE_ITEMS) begin
				send_request(random_request(), 1'b0, '0);
				// now and then hold off until the block has caught up
				if ($urandom_range(63) == 0)
					wait_until_drained();
				else
					sender_gap();
			end
		end

		wait_until_drained();
		$display("run: %0d requests, %0d frame_count settings incl. 0 and 8191",
			n_granted + n_released + n_nothing + n_full, PHASES + 5);
		$display("run: %0d granted, %0d freed, %0d nothing to do, %0d map full; %0d results checked",
			n_granted, n_released, n_nothing, n_full, results_seen);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
